// File: src/perlin_gradient_noise_3d_defines.svh
// Assertion macros shared by the noise block's RTL files.
// Depends on nothing; the including module must have clk and arst_n.
`ifndef PERLIN_GRADIENT_NOISE_3D_DEFINES_SVH
`define PERLIN_GRADIENT_NOISE_3D_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PGN_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PGN_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: src/pgn_pkg.sv
// Shared types, constants and helpers for the 3-D gradient noise block.
// Depends on nothing; used by every module of the block.
package pgn_pkg;

	localparam int TABLE_SIZE  = 256;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int QUEUE_DEPTH = 2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_GRAD = 2'd0,
		OP_PERM = 2'd1,
		OP_EVAL = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// One classified item as it travels from the front end to the back end.
	typedef struct packed {
		op_t                  kind;
		idx_t                 idx;
		logic [2:0][15:0]     grad;
		logic [2:0][7:0]      perm;
		logic [2:0][IDX_W-1:0] cell0;
		logic [2:0][IDX_W-1:0] cell1;
		logic [2:0][15:0]     frac;
	} item_t;

	// Reduces an 8-bit value to a table index, modulo the table size.
	function automatic idx_t idx_of(input logic [7:0] v);
		logic [IDX_W+7:0] wide;
		wide = {{IDX_W{1'b0}}, v};
		return wide[IDX_W-1:0];
	endfunction

endpackage

// File: src/perlin_gradient_noise_3d.sv
// Top level of the three-dimensional gradient noise block (quintic fade).
// Depends on pgn_pkg, pgn_front, pgn_queue and pgn_back.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | op, index, grad_x/y/z, perm_*_entry, point_*
//   output  | out_valid / out_ready| noise_value
//
// The block takes one item in every cycle, load or evaluate alike, unless the
// output stalls. An evaluate item's result passes through the front-end register,
// the queue and the thirteen back-end stages, the first of which loads as the
// queue is popped. The rate is set by the table read ports: each permutation
// table has two read ports and the gradient table is kept in four copies of two
// read ports each. Reset clears only the control state; the tables hold nothing
// defined until they are loaded. A stalled output freezes the back end, the
// queue then fills and in_ready falls, so nothing is lost or repeated.

module perlin_gradient_noise_3d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [7:0]         index,
	input  logic signed [15:0] grad_x,
	input  logic signed [15:0] grad_y,
	input  logic signed [15:0] grad_z,
	input  logic [7:0]         perm_x_entry,
	input  logic [7:0]         perm_y_entry,
	input  logic [7:0]         perm_z_entry,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value
);

	// Classified items leave the front end here.
	logic           front_valid;
	logic           front_ready;
	pgn_pkg::item_t front_item;

	// Head of the queue, as the back end sees it.
	logic           q_valid;
	logic           q_pop;
	pgn_pkg::item_t q_item;

	// The front end registers each item, drops the unused code and splits the
	// point into cell indexes and fractions.
	pgn_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.index        (index),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.grad_z       (grad_z),
		.perm_x_entry (perm_x_entry),
		.perm_y_entry (perm_y_entry),
		.perm_z_entry (perm_z_entry),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.item_valid   (front_valid),
		.item         (front_item),
		.item_ready   (front_ready)
	);

	// The queue lets the front end keep accepting while the back end stalls.
	pgn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid),
		.push_item  (front_item),
		.push_ready (front_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (q_pop)
	);

	// The back end applies loads to the tables in order and evaluates points;
	// its last stage is the output register.
	pgn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.noise_value (noise_value)
	);

endmodule

// File: src/pgn_front.sv
// Front end: accepts items, drops unused codes and splits points into cells.
// Depends on pgn_pkg and the assertion macro header.
`include "perlin_gradient_noise_3d_defines.svh"

module pgn_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [7:0]            index,
	input  logic signed [15:0]    grad_x,
	input  logic signed [15:0]    grad_y,
	input  logic signed [15:0]    grad_z,
	input  logic [7:0]            perm_x_entry,
	input  logic [7:0]            perm_y_entry,
	input  logic [7:0]            perm_z_entry,
	input  logic signed [31:0]    point_x,
	input  logic signed [31:0]    point_y,
	input  logic signed [31:0]    point_z,
	output logic                  item_valid,
	output pgn_pkg::item_t        item,
	input  logic                  item_ready
);

	logic           front_v_q;
	pgn_pkg::item_t item_q;
	pgn_pkg::item_t item_d;
	logic           accept;

	assign in_ready   = !front_v_q || item_ready;
	assign accept     = in_valid && in_ready;
	assign item_valid = front_v_q;
	assign item       = item_q;

	always_comb begin
		item_d.kind  = pgn_pkg::op_t'(op);
		item_d.idx   = pgn_pkg::idx_of(index);
		item_d.grad  = {grad_z, grad_y, grad_x};
		item_d.perm  = {perm_z_entry, perm_y_entry, perm_x_entry};
		item_d.cell0[0] = point_x[16 +: pgn_pkg::IDX_W];
		item_d.cell0[1] = point_y[16 +: pgn_pkg::IDX_W];
		item_d.cell0[2] = point_z[16 +: pgn_pkg::IDX_W];
		item_d.cell1[0] = pgn_pkg::idx_t'(point_x[16 +: pgn_pkg::IDX_W] + 1'b1);
		item_d.cell1[1] = pgn_pkg::idx_t'(point_y[16 +: pgn_pkg::IDX_W] + 1'b1);
		item_d.cell1[2] = pgn_pkg::idx_t'(point_z[16 +: pgn_pkg::IDX_W] + 1'b1);
		item_d.frac  = {point_z[15:0], point_y[15:0], point_x[15:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_v_q <= 1'b0;
		end else if (accept) begin
			front_v_q <= (pgn_pkg::op_t'(op) != pgn_pkg::OP_NONE);
		end else if (item_ready) begin
			front_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_d;
		end
	end

	`PGN_ASSERT_NEXT(a_unused_dropped, accept && (pgn_pkg::op_t'(op) == pgn_pkg::OP_NONE), !front_v_q, "unused op code was passed on")
	`PGN_ASSERT_NEXT(a_used_kept, accept && (pgn_pkg::op_t'(op) != pgn_pkg::OP_NONE), front_v_q, "accepted item was lost")

endmodule

// File: src/pgn_queue.sv
// Short queue that decouples the front end from the back end.
// Depends on pgn_pkg and the assertion macro header.
`include "perlin_gradient_noise_3d_defines.svh"

module pgn_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pgn_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output pgn_pkg::item_t pop_item,
	input  logic           pop
);

	localparam int PTR_W = (pgn_pkg::QUEUE_DEPTH > 1) ? $clog2(pgn_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(pgn_pkg::QUEUE_DEPTH + 1);

	pgn_pkg::item_t   store_q [pgn_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(pgn_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = store_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(pgn_pkg::QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	`PGN_ASSERT_NEXT(a_fill_count, do_push && !do_pop, count_q == CNT_W'($past(count_q) + 1'b1), "queue count did not rise on push")
	`PGN_ASSERT_NEXT(a_drain_count, do_pop && !do_push, count_q == CNT_W'($past(count_q) - 1'b1), "queue count did not fall on pop")

endmodule

// File: src/pgn_back.sv
// Back end: table reads, hashing, corner dots, fades and trilinear blend.
// Depends on pgn_pkg and the assertion macro header.
`include "perlin_gradient_noise_3d_defines.svh"

module pgn_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  pgn_pkg::item_t      q_item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  noise_value
);

	logic en;

	// Stage valids.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;

	// Stage 1: permutation reads and squared fractions.
	pgn_pkg::op_t     kind_s1;
	pgn_pkg::idx_t    idx_s1;
	logic [47:0]      grad_s1;
	logic [15:0]      frac_s1 [3];
	logic [31:0]      ff_s1 [3];
	logic [7:0]       perm_rd_s1 [3][2];
	logic [7:0]       perm_x_mem [pgn_pkg::TABLE_SIZE];
	logic [7:0]       perm_y_mem [pgn_pkg::TABLE_SIZE];
	logic [7:0]       perm_z_mem [pgn_pkg::TABLE_SIZE];

	// Stage 2: gradient reads and fade polynomial.
	pgn_pkg::idx_t    hash [8];
	logic [36:0]      csum [3];
	logic [47:0]      gd_s2 [8];
	logic [15:0]      frac_s2 [3];
	logic [31:0]      t2f_s2 [3];
	logic [19:0]      c_s2 [3];

	// Stage 3 and 4: corner products, sums and fade weights.
	logic signed [32:0] prod_d [8][3];
	logic signed [32:0] prod_s3 [8][3];
	logic [35:0]        t3c_s3 [3];
	logic signed [33:0] dot_s4 [8];
	logic [15:0]        fade_s4 [3], fade_s5 [3], fade_s6 [3], fade_s7 [3];
	logic [15:0]        fade_s8 [3], fade_s9 [3], fade_s10 [3], fade_s11 [3];

	// Blend stages.
	logic signed [33:0] a_s5 [4], a_s6 [4];
	logic signed [34:0] d_s5 [4];
	logic signed [51:0] p_s6 [4];
	logic signed [33:0] l_s7 [4];
	logic signed [33:0] a_s8 [2], a_s9 [2];
	logic signed [34:0] d_s8 [2];
	logic signed [51:0] p_s9 [2];
	logic signed [33:0] l_s10 [2];
	logic signed [33:0] a_s11, a_s12;
	logic signed [34:0] d_s11;
	logic signed [51:0] p_s12;
	logic signed [33:0] blend_sum;
	logic signed [34:0] round_sum;
	logic signed [34:0] rounded;
	logic signed [15:0] noise_s13;

	assign en          = !v_s13 || out_ready;
	assign pop         = en && q_valid;
	assign out_valid   = v_s13;
	assign noise_value = noise_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s1  <= q_valid;
			v_s2  <= v_s1 && (kind_s1 == pgn_pkg::OP_EVAL);
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// Permutation tables: one write port, two read ports (cell and cell + 1).
	always_ff @(posedge clk) begin
		if (en) begin
			if (q_valid && (q_item.kind == pgn_pkg::OP_PERM)) begin
				perm_x_mem[q_item.idx] <= q_item.perm[0];
				perm_y_mem[q_item.idx] <= q_item.perm[1];
				perm_z_mem[q_item.idx] <= q_item.perm[2];
			end
			perm_rd_s1[0][0] <= perm_x_mem[q_item.cell0[0]];
			perm_rd_s1[0][1] <= perm_x_mem[q_item.cell1[0]];
			perm_rd_s1[1][0] <= perm_y_mem[q_item.cell0[1]];
			perm_rd_s1[1][1] <= perm_y_mem[q_item.cell1[1]];
			perm_rd_s1[2][0] <= perm_z_mem[q_item.cell0[2]];
			perm_rd_s1[2][1] <= perm_z_mem[q_item.cell1[2]];
		end
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			hash[k] = pgn_pkg::idx_of(perm_rd_s1[0][k[0]] ^ perm_rd_s1[1][k[1]]
				^ perm_rd_s1[2][k[2]]);
		end
		for (int a = 0; a < 3; a++) begin
			csum[a] = 37'(ff_s1[a]) * 37'd6 - 37'(frac_s1[a]) * 37'd983040
				+ 37'h0A_0000_0000;
		end
	end

	// Gradient table in four copies, each serving two corners.
	for (genvar c = 0; c < 4; c++) begin : g_grad_copy
		logic [47:0] grad_mem [pgn_pkg::TABLE_SIZE];
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s1 && (kind_s1 == pgn_pkg::OP_GRAD)) begin
					grad_mem[idx_s1] <= grad_s1;
				end
				gd_s2[2*c]   <= grad_mem[hash[2*c]];
				gd_s2[2*c+1] <= grad_mem[hash[2*c+1]];
			end
		end
	end

	// Corner offsets are F or F - 1; in 17 bits that is the fraction with a sign bit.
	always_comb begin
		logic signed [15:0] gv;
		logic signed [16:0] ov;
		for (int k = 0; k < 8; k++) begin
			for (int a = 0; a < 3; a++) begin
				gv = $signed(gd_s2[k][16*a +: 16]);
				ov = $signed({k[a], frac_s2[a]});
				prod_d[k][a] = 33'(gv) * 33'(ov);
			end
		end
	end

	assign blend_sum = a_s12 + 34'(p_s12 >>> 16);
	assign round_sum = 35'(blend_sum) + 35'sd32768;
	assign rounded   = round_sum >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= q_item.kind;
			idx_s1  <= q_item.idx;
			grad_s1 <= q_item.grad;
			for (int a = 0; a < 3; a++) begin
				frac_s1[a] <= q_item.frac[a];
				ff_s1[a]   <= 32'(q_item.frac[a]) * 32'(q_item.frac[a]);
				frac_s2[a] <= frac_s1[a];
				t2f_s2[a]  <= 32'(ff_s1[a][31:16]) * 32'(frac_s1[a]);
				c_s2[a]    <= csum[a][35:16];
				t3c_s3[a]  <= 36'(t2f_s2[a][31:16]) * 36'(c_s2[a]);
				fade_s4[a] <= t3c_s3[a][31:16];
			end
			prod_s3 <= prod_d;
			for (int k = 0; k < 8; k++) begin
				dot_s4[k] <= 34'(prod_s3[k][0]) + 34'(prod_s3[k][1]) + 34'(prod_s3[k][2]);
			end
			fade_s5  <= fade_s4;
			fade_s6  <= fade_s5;
			fade_s7  <= fade_s6;
			fade_s8  <= fade_s7;
			fade_s9  <= fade_s8;
			fade_s10 <= fade_s9;
			fade_s11 <= fade_s10;
			// Blend along x.
			for (int j = 0; j < 4; j++) begin
				a_s5[j] <= dot_s4[2*j];
				d_s5[j] <= 35'(dot_s4[2*j+1]) - 35'(dot_s4[2*j]);
				a_s6[j] <= a_s5[j];
				p_s6[j] <= 52'(d_s5[j]) * 52'($signed({1'b0, fade_s5[0]}));
				l_s7[j] <= a_s6[j] + 34'(p_s6[j] >>> 16);
			end
			// Blend along y.
			for (int i = 0; i < 2; i++) begin
				a_s8[i]  <= l_s7[2*i];
				d_s8[i]  <= 35'(l_s7[2*i+1]) - 35'(l_s7[2*i]);
				a_s9[i]  <= a_s8[i];
				p_s9[i]  <= 52'(d_s8[i]) * 52'($signed({1'b0, fade_s8[1]}));
				l_s10[i] <= a_s9[i] + 34'(p_s9[i] >>> 16);
			end
			// Blend along z, round half up and saturate.
			a_s11 <= l_s10[0];
			d_s11 <= 35'(l_s10[1]) - 35'(l_s10[0]);
			a_s12 <= a_s11;
			p_s12 <= 52'(d_s11) * 52'($signed({1'b0, fade_s11[2]}));
			if (rounded > 35'sd32767) begin
				noise_s13 <= 16'sh7FFF;
			end else if (rounded < -35'sd32768) begin
				noise_s13 <= 16'sh8000;
			end else begin
				noise_s13 <= rounded[15:0];
			end
		end
	end

	`PGN_ASSERT_NEXT(a_eval_enters, en && v_s1 && (kind_s1 == pgn_pkg::OP_EVAL), v_s2, "evaluate item lost after table read")
	`PGN_ASSERT_NEXT(a_load_retires, en && v_s1 && (kind_s1 != pgn_pkg::OP_EVAL), !v_s2, "load item produced a result")

endmodule

// File: bench/testbench.sv
// Self-checking bench for the 3-D gradient noise block: loads gradient and permutation tables,
// evaluates points and compares each noise value with an in-bench fixed-point predictor.
// Depends on pgn_pkg and perlin_gradient_noise_3d.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;

	// One input item as the driver presents it.
	typedef struct {
		pgn_pkg::op_t kind;
		logic [7:0]  idx;
		logic [15:0] gx, gy, gz;
		logic [7:0]  px, py, pz;
		logic [31:0] ptx, pty, ptz;
	} noise_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = pgn_pkg::OP_NONE;
	logic [7:0] index = '0;
	logic signed [15:0] grad_x = '0, grad_y = '0, grad_z = '0;
	logic [7:0] perm_x_entry = '0, perm_y_entry = '0, perm_z_entry = '0;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] noise_value;

	perlin_gradient_noise_3d dut (.*);

	// Clock: 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The bench's own copy of the tables, updated as each item is accepted.
	logic [47:0] grad_mem [256];
	logic [7:0]  perm_x_mem [256];
	logic [7:0]  perm_y_mem [256];
	logic [7:0]  perm_z_mem [256];

	noise_item_t pending_items [$];
	logic signed [15:0] expected_noise [$];
	int  error_count = 0;
	bit  stimulus_done = 1'b0;
	bit  quiet_tail = 1'b0;
	int  in_gap = 0, out_gap = 0;
	int  idle_cycles = 0;

	// Quintic fade of a Q0.16 fraction, truncating as the block does.
	function automatic longint fade_weight(input longint f);
		longint c, t2, t3;
		c  = (6*f*f - 15*65536*f + 10*(longint'(1) << 32)) >>> 16;
		t2 = (f*f) >>> 16;
		t3 = (t2*f) >>> 16;
		return (t3*c) >>> 16;
	endfunction

	// Linear blend with a floored product; >>> on longint is a true floor.
	function automatic longint blend(input longint a, input longint b, input longint w);
		return a + (((b - a) * w) >>> 16);
	endfunction

	function automatic longint corner_dot(input logic [15:0] cx, input logic [15:0] cy,
			input logic [15:0] cz, input longint ox, input longint oy, input longint oz);
		logic [7:0] h;
		logic [47:0] g;
		h = perm_x_mem[cx[7:0]] ^ perm_y_mem[cy[7:0]] ^ perm_z_mem[cz[7:0]];
		g = grad_mem[h];
		return longint'($signed(g[15:0])) * ox + longint'($signed(g[31:16])) * oy
			+ longint'($signed(g[47:32])) * oz;
	endfunction

	// Noise at one Q16.16 point, rounded half up and saturated to Q1.15.
	function automatic logic signed [15:0] noise_at(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		logic [15:0] cx, cy, cz;
		longint fx, fy, fz, ex, ey, ez, wu, wv, ww, lo, hi, s, r;
		cx = x[31:16]; cy = y[31:16]; cz = z[31:16];
		fx = x[15:0]; fy = y[15:0]; fz = z[15:0];
		ex = fx - 65536; ey = fy - 65536; ez = fz - 65536;
		wu = fade_weight(fx); wv = fade_weight(fy); ww = fade_weight(fz);
		lo = blend(blend(corner_dot(cx, cy, cz, fx, fy, fz),
				corner_dot(cx + 16'd1, cy, cz, ex, fy, fz), wu),
			blend(corner_dot(cx, cy + 16'd1, cz, fx, ey, fz),
				corner_dot(cx + 16'd1, cy + 16'd1, cz, ex, ey, fz), wu), wv);
		hi = blend(blend(corner_dot(cx, cy, cz + 16'd1, fx, fy, ez),
				corner_dot(cx + 16'd1, cy, cz + 16'd1, ex, fy, ez), wu),
			blend(corner_dot(cx, cy + 16'd1, cz + 16'd1, fx, ey, ez),
				corner_dot(cx + 16'd1, cy + 16'd1, cz + 16'd1, ex, ey, ez), wu), wv);
		s = blend(lo, hi, ww);
		r = (s + 32768) >>> 16;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	// Applies an accepted item to the bench's tables, or predicts its result.
	task automatic track_item(input noise_item_t it);
		case (it.kind)
			pgn_pkg::OP_GRAD: grad_mem[it.idx] = {it.gz, it.gy, it.gx};
			pgn_pkg::OP_PERM: begin
				perm_x_mem[it.idx] = it.px;
				perm_y_mem[it.idx] = it.py;
				perm_z_mem[it.idx] = it.pz;
			end
			pgn_pkg::OP_EVAL: expected_noise.push_back(noise_at(it.ptx, it.pty, it.ptz));
			default: ;
		endcase
	endtask

	function automatic noise_item_t blank_item(input pgn_pkg::op_t k);
		noise_item_t it;
		it.kind = k;
		it.idx = 8'($urandom);
		it.gx = 16'($urandom); it.gy = 16'($urandom); it.gz = 16'($urandom);
		it.px = 8'($urandom); it.py = 8'($urandom); it.pz = 8'($urandom);
		it.ptx = $urandom; it.pty = $urandom; it.ptz = $urandom;
		return it;
	endfunction

	function automatic noise_item_t point_item(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		noise_item_t it;
		it = blank_item(pgn_pkg::OP_EVAL);
		it.ptx = x; it.pty = y; it.ptz = z;
		return it;
	endfunction

	// Driver: presents the head of the queue, holding it until it is taken.
	always @(posedge clk) begin
		noise_item_t it;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				it = pending_items.pop_front();
				track_item(it);
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					it = pending_items[0];
					in_valid <= 1'b1;
					op <= it.kind;
					index <= it.idx;
					grad_x <= it.gx; grad_y <= it.gy; grad_z <= it.gz;
					perm_x_entry <= it.px; perm_y_entry <= it.py; perm_z_entry <= it.pz;
					point_x <= it.ptx; point_y <= it.pty; point_z <= it.ptz;
					if (!quiet_tail && $urandom_range(0, 9) == 0)
						in_gap <= $urandom_range(1, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result and stalls the output in bursts.
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_noise.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d",
						$time, noise_value);
					error_count++;
				end else begin
					want = expected_noise.pop_front();
					if (noise_value !== want) begin
						$display("%0t: noise_value mismatch, expected %0d, actual %0d",
							$time, want, noise_value);
						error_count++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet_tail && $urandom_range(0, 9) == 0)
					out_gap <= $urandom_range(1, 10);
			end
			// Watchdog: counts cycles with no handshake on either side.
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus. Every table entry is written before any evaluate, so no read ever touches
	// an unwritten entry; later loads overwrite entries with fresh random content.
	initial begin
		noise_item_t it;
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 256; i++) begin
			it = blank_item(pgn_pkg::OP_GRAD); it.idx = 8'(i);
			// Extreme gradients at a few entries so that the final value saturates.
			if (i < 8) begin
				it.gx = (i & 1) ? 16'h8000 : 16'h7fff;
				it.gy = (i & 2) ? 16'h8000 : 16'h7fff;
				it.gz = (i & 4) ? 16'h8000 : 16'h7fff;
			end
			pending_items.push_back(it);
			it = blank_item(pgn_pkg::OP_PERM); it.idx = 8'(i);
			pending_items.push_back(it);
		end

		// Directed points: zero, integer corners, extremes of the coordinate range,
		// negative exact integers, and fractions at zero and just under one.
		pending_items.push_back(point_item(0, 0, 0));
		pending_items.push_back(point_item(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
		pending_items.push_back(point_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_items.push_back(point_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		pending_items.push_back(point_item(32'hffff_0000, 32'hfffe_0000, 32'h0001_0000));
		pending_items.push_back(point_item(32'hffff_ffff, 32'h0000_0001, 32'h0000_ffff));
		pending_items.push_back(point_item(32'h00ff_ffff, 32'h0100_0000, 32'h7fff_0000));
		// Make every corner of cell 0 use the saturating gradients, then evaluate there.
		for (int i = 0; i < 2; i++) begin
			it = blank_item(pgn_pkg::OP_PERM); it.idx = 8'(i);
			it.px = 8'h00; it.py = 8'h00; it.pz = 8'h00;
			pending_items.push_back(it);
		end
		it = blank_item(pgn_pkg::OP_GRAD); it.idx = 8'd0;
		it.gx = 16'h8000; it.gy = 16'h8000; it.gz = 16'h8000;
		pending_items.push_back(it);
		pending_items.push_back(point_item(32'h0000_ffff, 32'h0000_ffff, 32'h0000_ffff));
		pending_items.push_back(point_item(32'h0000_8000, 32'h0000_0001, 32'h0000_c000));
		// Unused op: ignored and gives nothing.
		pending_items.push_back(blank_item(pgn_pkg::OP_NONE));
		pending_items.push_back(point_item(32'h0001_4000, 32'hfff0_2000, 32'h0003_e000));

		// Random part: mostly evaluates, with reloads and a little of the unused op.
		for (int i = 0; i < 870; i++) begin
			n = $urandom_range(0, 19);
			if (n < 3) it = blank_item(pgn_pkg::OP_GRAD);
			else if (n < 6) it = blank_item(pgn_pkg::OP_PERM);
			else if (n == 6) it = blank_item(pgn_pkg::OP_NONE);
			else it = blank_item(pgn_pkg::OP_EVAL);
			pending_items.push_back(it);
			if (i == 720) begin
				wait (pending_items.size() < 10);
				quiet_tail = 1'b1;
			end
		end
		stimulus_done = 1'b1;
	end

	// End of run: drain, settle, then report.
	initial begin
		wait (stimulus_done);
		wait (pending_items.size() == 0 && !in_valid && expected_noise.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_noise.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t: watchdog expired", $time);
		$display("testbench: errors");
		$finish;
	end

endmodule
